// ===== design/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// shared constants for the rotation matrix to quaternion block
// ----------------------------------------------------------------------------
`default_nettype none
package rmq_pkg;
   localparam int FRAC_BITS_DEF  = 14;
   localparam int DATA_WIDTH_DEF = 16;
endpackage
`default_nettype wire

// ===== design/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_sqrt #(
   parameter int IN_W = 32,
   parameter int TAG_W = 8
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire logic [IN_W-1:0]     in_rad,
   input  wire logic [TAG_W-1:0]    in_tag,
   output logic                     out_valid,
   output logic [IN_W/2-1:0]        out_root,
   output logic [TAG_W-1:0]         out_tag
);
   localparam int STEPS = IN_W / 2;
   localparam int RW = IN_W / 2 + 2;

   logic [STEPS:0]            vld_ff;
   logic [IN_W-1:0]           rem_ff [STEPS+1];
   logic [STEPS-1:0]          res_ff [STEPS+1];
   logic [IN_W-1:0]           num_ff [STEPS+1];
   logic [TAG_W-1:0]          tag_ff [STEPS+1];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[STEPS-1:0], in_valid};
   end

   // stage zero captures the operand
   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      res_ff[0] <= '0;
      num_ff[0] <= in_rad;
      tag_ff[0] <= in_tag;
   end

   // restoring root, two radicand bits per stage
   for (genvar g = 0; g < STEPS; g++) begin : g_step
      logic [RW-1:0] rem_in;
      logic [RW-1:0] trial;
      always_comb begin
         rem_in = {rem_ff[g][RW-3:0], num_ff[g][IN_W-1 -: 2]};
         trial  = {res_ff[g], 2'b01};
      end
      always_ff @(posedge clock) begin
         num_ff[g+1] <= num_ff[g] << 2;
         tag_ff[g+1] <= tag_ff[g];
         if (rem_in >= trial) begin
            rem_ff[g+1] <= IN_W'(rem_in - trial);
            res_ff[g+1] <= {res_ff[g][STEPS-2:0], 1'b1};
         end else begin
            rem_ff[g+1] <= IN_W'(rem_in);
            res_ff[g+1] <= {res_ff[g][STEPS-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[STEPS];
   assign out_root  = res_ff[STEPS];
   assign out_tag   = tag_ff[STEPS];
endmodule
`default_nettype wire

// ===== design/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// pipelined unsigned restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`default_nettype none
module rmq_div #(
   parameter int N_W = 48,
   parameter int D_W = 24,
   parameter int TAG_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire logic [N_W-1:0]    in_num,
   input  wire logic [D_W-1:0]    in_den,
   input  wire logic [TAG_W-1:0]  in_tag,
   output logic                   out_valid,
   output logic [N_W-1:0]         out_quo,
   output logic [TAG_W-1:0]       out_tag
);
   logic [N_W:0]        vld_ff;
   logic [D_W:0]        rem_ff [N_W+1];
   logic [N_W-1:0]      quo_ff [N_W+1];
   logic [D_W-1:0]      den_ff [N_W+1];
   logic [TAG_W-1:0]    tag_ff [N_W+1];

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else vld_ff <= {vld_ff[N_W-1:0], in_valid};
   end

   // operand capture
   always_ff @(posedge clock) begin
      rem_ff[0] <= '0;
      quo_ff[0] <= in_num;
      den_ff[0] <= in_den;
      tag_ff[0] <= in_tag;
   end

   // shift numerator bits through the remainder
   for (genvar g = 0; g < N_W; g++) begin : g_step
      logic [D_W+1:0] sh;
      always_comb sh = {rem_ff[g], quo_ff[g][N_W-1]};
      always_ff @(posedge clock) begin
         den_ff[g+1] <= den_ff[g];
         tag_ff[g+1] <= tag_ff[g];
         if (sh >= {2'b00, den_ff[g]}) begin
            rem_ff[g+1] <= (D_W+1)'(sh - {2'b00, den_ff[g]});
            quo_ff[g+1] <= {quo_ff[g][N_W-2:0], 1'b1};
         end else begin
            rem_ff[g+1] <= (D_W+1)'(sh);
            quo_ff[g+1] <= {quo_ff[g][N_W-2:0], 1'b0};
         end
      end
   end

   assign out_valid = vld_ff[N_W];
   assign out_quo   = quo_ff[N_W];
   assign out_tag   = tag_ff[N_W];
endmodule
`default_nettype wire

// ===== design/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// rotation matrix to unit quaternion, trace or largest-diagonal branch
// selection, pipelined
// ----------------------------------------------------------------------------
//  channel   ports                     handshake
//  request   req_r0c0..req_r2c2        start / busy
//  response  rsp_qx..qw, degenerate    rsp_valid strobe, no backpressure
//
//  one transaction per cycle; busy is always low
//  rsp_valid follows the accepting edge through the pipeline stages: input register 1,
//  roots 18 + 18, divides 34 + 31, square and sum 2, output register 1
//  each one quotient or root bit per stage
//  reset clears valid bits only; no state survives between transactions
// ----------------------------------------------------------------------------
`default_nettype none
module rotation_matrix_to_quaternion #(
   parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF,
   parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [DATA_WIDTH-1:0] req_r0c0,
   input  wire logic signed [DATA_WIDTH-1:0] req_r0c1,
   input  wire logic signed [DATA_WIDTH-1:0] req_r0c2,
   input  wire logic signed [DATA_WIDTH-1:0] req_r1c0,
   input  wire logic signed [DATA_WIDTH-1:0] req_r1c1,
   input  wire logic signed [DATA_WIDTH-1:0] req_r1c2,
   input  wire logic signed [DATA_WIDTH-1:0] req_r2c0,
   input  wire logic signed [DATA_WIDTH-1:0] req_r2c1,
   input  wire logic signed [DATA_WIDTH-1:0] req_r2c2,
   output logic                              rsp_valid,
   output logic signed [DATA_WIDTH-1:0]      rsp_qx,
   output logic signed [DATA_WIDTH-1:0]      rsp_qy,
   output logic signed [DATA_WIDTH-1:0]      rsp_qz,
   output logic signed [DATA_WIDTH-1:0]      rsp_qw,
   output logic                              rsp_degenerate
);
   // widths
   localparam int AW  = DATA_WIDTH + 3;             // radicand / numerator
   localparam int RADW = 2 * ((AW + FRAC_BITS + 1) / 2);
   localparam int RTW = RADW / 2;                   // root width
   localparam int CW  = FRAC_BITS + 2;              // component magnitude
   localparam int N1W = AW + FRAC_BITS;             // first divide numerator
   localparam int SQW = 2 * (2 * CW + 2) / 2;       // sum of squares width
   localparam int LW  = SQW / 2;
   localparam int N2W = CW + FRAC_BITS;
   localparam logic [CW-1:0] CMAX = CW'((64'd1 << (FRAC_BITS + 1)) - 1);
   localparam logic [N2W-1:0] LIM2 = N2W'(64'd1 << (FRAC_BITS + 1));
   localparam int TAG1 = 3 * (AW + 1) + 2;          // signs, numerators, own idx
   localparam int TAG2 = 4 * (CW + 1) + 1;

   assign busy = 1'b0;

   // ---------------- stage A: branch select and radicand ----------------
   logic signed [AW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22, one_q, tr;
   logic signed [AW-1:0] rad, n0, n1, n2;
   logic [1:0]           own;
   always_comb begin
      a00 = AW'(req_r0c0); a01 = AW'(req_r0c1); a02 = AW'(req_r0c2);
      a10 = AW'(req_r1c0); a11 = AW'(req_r1c1); a12 = AW'(req_r1c2);
      a20 = AW'(req_r2c0); a21 = AW'(req_r2c1); a22 = AW'(req_r2c2);
      one_q = AW'(64'sd1 <<< FRAC_BITS);
      tr = a00 + a11 + a22;
      if (tr > 0) begin
         rad = tr + one_q; own = 2'd3;
         n0 = a12 - a21; n1 = a20 - a02; n2 = a01 - a10;
      end else if (a00 > a11 && a00 > a22) begin
         rad = one_q + a00 - a11 - a22; own = 2'd0;
         n0 = a12 - a21; n1 = a01 + a10; n2 = a02 + a20;
      end else if (a11 > a22) begin
         rad = one_q + a11 - a00 - a22; own = 2'd1;
         n0 = a20 - a02; n1 = a01 + a10; n2 = a12 + a21;
      end else begin
         rad = one_q + a22 - a00 - a11; own = 2'd2;
         n0 = a01 - a10; n1 = a02 + a20; n2 = a12 + a21;
      end
   end

   logic                 a_vld_ff;
   logic                 a_bad_ff;
   logic [RADW-1:0]      a_rad_ff;
   logic [TAG1-1:0]      a_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else a_vld_ff <= start;
      a_bad_ff <= (rad <= 0);
      a_rad_ff <= (rad <= 0) ? '0 : RADW'({{(RADW-AW){1'b0}}, rad} << FRAC_BITS);
      a_tag_ff <= {own, n0[AW-1], AW'(n0 < 0 ? -n0 : n0), n1[AW-1],
                   AW'(n1 < 0 ? -n1 : n1), n2[AW-1], AW'(n2 < 0 ? -n2 : n2)};
   end

   // ---------------- first root ----------------
   logic              s1_vld;
   logic [RTW-1:0]    s1_root;
   logic [TAG1:0]     s1_tag;
   rmq_sqrt #(.IN_W(RADW), .TAG_W(TAG1 + 1)) u_root1 (
      .clock, .reset, .in_valid(a_vld_ff), .in_rad(a_rad_ff),
      .in_tag({a_bad_ff, a_tag_ff}), .out_valid(s1_vld), .out_root(s1_root),
      .out_tag(s1_tag)
   );

   // ---------------- three component divides ----------------
   logic             s1_bad;
   logic [1:0]       s1_own;
   logic             sg [3];
   logic [AW-1:0]    mg [3];
   logic [RTW:0]     den1;
   always_comb begin
      {s1_bad, s1_own, sg[0], mg[0], sg[1], mg[1], sg[2], mg[2]} = s1_tag;
      den1 = {s1_root, 1'b0};
   end
   localparam int OWNT = CW + 2 + 1;
   logic [OWNT-1:0]  own_tag;
   logic [CW-1:0]    own_c;
   always_comb begin
      own_c = ({1'b0, s1_root} + 1'b1) >> 1 > (RTW+1)'(CMAX) ? CMAX
            : CW'(({1'b0, s1_root} + 1'b1) >> 1);
      own_tag = {s1_bad || s1_root == '0, s1_own, own_c};
   end

   logic             d_vld [3];
   logic [N1W-1:0]   d_quo [3];
   logic [OWNT:0]    d_tag [3];
   for (genvar k = 0; k < 3; k++) begin : g_div1
      rmq_div #(.N_W(N1W), .D_W(RTW + 1), .TAG_W(OWNT + 1)) u_div (
         .clock, .reset, .in_valid(s1_vld),
         .in_num(N1W'({mg[k], {FRAC_BITS{1'b0}}} + N1W'(den1 >> 1))),
         .in_den(s1_root == '0 ? (RTW+1)'(1) : den1),
         .in_tag({sg[k], own_tag}), .out_valid(d_vld[k]), .out_quo(d_quo[k]),
         .out_tag(d_tag[k])
      );
   end

   // ---------------- stage C: assemble components, square ----------------
   logic            c_bad;
   logic [1:0]      c_own;
   logic [CW-1:0]   c_ownv;
   logic [CW-1:0]   cm [3];
   logic [CW-1:0]   qm [4];
   logic            qs [4];
   always_comb begin
      {c_bad, c_own, c_ownv} = d_tag[0][OWNT-1:0];
      for (int k = 0; k < 3; k++)
         cm[k] = d_quo[k] > N1W'(CMAX) ? CMAX : CW'(d_quo[k]);
      // own from the root; divides fill w first if free, then the rest in index order
      qm[c_own] = c_ownv; qs[c_own] = 1'b0;
      case (c_own)
         2'd3: begin
            qm[0] = cm[0]; qs[0] = d_tag[0][OWNT];
            qm[1] = cm[1]; qs[1] = d_tag[1][OWNT];
            qm[2] = cm[2]; qs[2] = d_tag[2][OWNT];
         end
         2'd0: begin
            qm[3] = cm[0]; qs[3] = d_tag[0][OWNT];
            qm[1] = cm[1]; qs[1] = d_tag[1][OWNT];
            qm[2] = cm[2]; qs[2] = d_tag[2][OWNT];
         end
         2'd1: begin
            qm[3] = cm[0]; qs[3] = d_tag[0][OWNT];
            qm[0] = cm[1]; qs[0] = d_tag[1][OWNT];
            qm[2] = cm[2]; qs[2] = d_tag[2][OWNT];
         end
         default: begin
            qm[3] = cm[0]; qs[3] = d_tag[0][OWNT];
            qm[0] = cm[1]; qs[0] = d_tag[1][OWNT];
            qm[1] = cm[2]; qs[1] = d_tag[2][OWNT];
         end
      endcase
   end

   // squares registered, then summed
   logic            c_vld_ff, e_vld_ff;
   logic [2*CW-1:0] sq_ff [4];
   logic [CW-1:0]   cq_ff [4], eq_ff [4];
   logic            cs_ff [4], es_ff [4];
   logic            cb_ff, eb_ff;
   logic [SQW-1:0]  sum_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= d_vld[0];
         e_vld_ff <= c_vld_ff;
      end
      cb_ff <= c_bad;
      eb_ff <= cb_ff;
      sum_ff <= SQW'(sq_ff[0]) + SQW'(sq_ff[1]) + SQW'(sq_ff[2]) + SQW'(sq_ff[3]);
      for (int k = 0; k < 4; k++) begin
         sq_ff[k] <= qm[k] * qm[k];
         cq_ff[k] <= qm[k]; cs_ff[k] <= qs[k];
         eq_ff[k] <= cq_ff[k]; es_ff[k] <= cs_ff[k];
      end
   end

   // ---------------- length root ----------------
   logic            l_vld;
   logic [LW-1:0]   l_root;
   logic [TAG2-1:0] l_tag;
   rmq_sqrt #(.IN_W(SQW), .TAG_W(TAG2)) u_root2 (
      .clock, .reset, .in_valid(e_vld_ff), .in_rad(sum_ff),
      .in_tag({eb_ff, es_ff[0], eq_ff[0], es_ff[1], eq_ff[1], es_ff[2], eq_ff[2],
               es_ff[3], eq_ff[3]}),
      .out_valid(l_vld), .out_root(l_root), .out_tag(l_tag)
   );

   // ---------------- normalize divides ----------------
   logic           l_bad;
   logic           ls [4];
   logic [CW-1:0]  lm [4];
   always_comb
      {l_bad, ls[0], lm[0], ls[1], lm[1], ls[2], lm[2], ls[3], lm[3]} = l_tag;

   logic            o_vld [4];
   logic [N2W-1:0]  o_quo [4];
   logic [1:0]      o_tag [4];
   for (genvar k = 0; k < 4; k++) begin : g_div2
      rmq_div #(.N_W(N2W), .D_W(LW), .TAG_W(2)) u_div (
         .clock, .reset, .in_valid(l_vld),
         .in_num(N2W'({lm[k], {FRAC_BITS{1'b0}}}) + N2W'(l_root >> 1)),
         .in_den(l_root == '0 ? LW'(1) : l_root),
         .in_tag({l_bad || l_root == '0, ls[k]}), .out_valid(o_vld[k]),
         .out_quo(o_quo[k]), .out_tag(o_tag[k])
      );
   end

   // ---------------- output saturation and register ----------------
   localparam logic signed [DATA_WIDTH:0] WMAXV = (DATA_WIDTH+1)'((64'd1 << (DATA_WIDTH-1)) - 1);
   localparam logic signed [N2W+1:0] HI = (FRAC_BITS < DATA_WIDTH - 1)
      ? (N2W+2)'(64'd1 << FRAC_BITS) : (N2W+2)'(WMAXV);
   logic signed [N2W+1:0] ov [4];
   logic signed [DATA_WIDTH-1:0] ow [4];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         ov[k] = (N2W+2)'(o_quo[k] > LIM2 ? LIM2 : o_quo[k]);
         if (o_tag[k][0]) ov[k] = -ov[k];
         if (ov[k] > HI) ov[k] = HI;
         if (ov[k] < -HI - ((FRAC_BITS < DATA_WIDTH - 1) ? 0 : 1))
            ov[k] = -HI - ((FRAC_BITS < DATA_WIDTH - 1) ? 0 : 1);
         ow[k] = DATA_WIDTH'(ov[k]);
      end
   end

   logic rv_ff, rd_ff;
   logic signed [DATA_WIDTH-1:0] rq_ff [4];
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else rv_ff <= o_vld[0];
      rd_ff <= o_tag[0][1];
      for (int k = 0; k < 3; k++) rq_ff[k] <= o_tag[0][1] ? '0 : ow[k];
      rq_ff[3] <= o_tag[0][1] ? DATA_WIDTH'(HI) : ow[3];
   end

   assign rsp_valid      = rv_ff;
   assign rsp_degenerate = rd_ff;
   assign rsp_qx = rq_ff[0];
   assign rsp_qy = rq_ff[1];
   assign rsp_qz = rq_ff[2];
   assign rsp_qw = rq_ff[3];

`ifndef NO_ASSERTIONS
   // the block never holds off a request
   a_busy_low: assert property (@(posedge clock) !busy)
      else $error("busy asserted");
   // degenerate results are the identity
   a_ident: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_qx == '0 && rsp_qy == '0 && rsp_qz == '0)
      else $error("degenerate result not identity");
   // divider lanes stay aligned
   a_lanes: assert property (@(posedge clock) disable iff (reset)
      o_vld[0] == o_vld[3] && d_vld[0] == d_vld[2])
      else $error("lane valid mismatch");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion
// drives directed, rotation and random matrices through the block with random gaps and compares
// every quaternion and degenerate flag with an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
`default_nettype none
module tb_rotation_matrix_to_quaternion;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FB    = rmq_pkg::FRAC_BITS_DEF;
   localparam int DW    = rmq_pkg::DATA_WIDTH_DEF;
   localparam longint ONE   = longint'(1) << FB;
   localparam longint CLAMP = (longint'(1) << (FB + 1)) - 1;
   localparam int N_RANDOM  = 1600;
   localparam int DRAIN     = 400;
   localparam longint CYCLE_LIMIT = 600000;

   typedef logic signed [DW-1:0] word_type;
   typedef struct packed {
      word_type [8:0] m;
   } matrix_type;
   typedef struct packed {
      word_type qx, qy, qz, qw;
      logic  degen;
   } quat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   word_type req_m [9];
   logic rsp_valid, rsp_degenerate;
   word_type rsp_qx, rsp_qy, rsp_qz, rsp_qw;

   matrix_type pending_matrices [$];
   quat_type   expected_quats [$];
   bit      stim_done = 1'b0;
   bit      hold_off = 1'b0;
   int      errors = 0;
   longint  cycles = 0;
   int      gap = 0;

   initial for (int i = 0; i < 9; i++) req_m[i] = '0;

   always #4 clock = ~clock;

   rotation_matrix_to_quaternion u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_r0c0(req_m[0]), .req_r0c1(req_m[1]), .req_r0c2(req_m[2]),
      .req_r1c0(req_m[3]), .req_r1c1(req_m[4]), .req_r1c2(req_m[5]),
      .req_r2c0(req_m[6]), .req_r2c1(req_m[7]), .req_r2c2(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_qx(rsp_qx), .rsp_qy(rsp_qy), .rsp_qz(rsp_qz),
      .rsp_qw(rsp_qw), .rsp_degenerate(rsp_degenerate)
   );

   // integer square root, floor
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // fixed-point divide, rounded half away from zero, magnitude limited
   function automatic longint fixed_div(longint num, longint unsigned d, longint lim);
      longint unsigned mag, q;
      longint m;
      mag = (num < 0) ? longint'(-num) : longint'(num);
      q = ((mag << FB) + (d >> 1)) / d;
      m = (q > longint'(lim)) ? lim : longint'(q);
      return (num < 0) ? -m : m;
   endfunction

   function automatic word_type sat_out(longint v);
      longint hi, lo;
      hi = (ONE < (longint'(1) << (DW - 1)) - 1) ? ONE : (longint'(1) << (DW - 1)) - 1;
      lo = (-ONE < -(longint'(1) << (DW - 1))) ? -(longint'(1) << (DW - 1)) : -ONE;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return word_type'(v);
   endfunction

   // trace or largest-diagonal branch selection and normalization
   function automatic quat_type quat_from_matrix(matrix_type mx);
      longint a [9];
      longint q [4];
      longint rad, n0, n1, n2, tr;
      int own, o0, o1, o2;
      longint unsigned r, d, sum, len, mg;
      quat_type res;
      for (int i = 0; i < 9; i++) a[i] = longint'(mx.m[i]);
      tr = a[0] + a[4] + a[8];
      if (tr > 0) begin
         rad = tr + ONE; own = 3; o0 = 0; o1 = 1; o2 = 2;
         n0 = a[5] - a[7]; n1 = a[6] - a[2]; n2 = a[1] - a[3];
      end else if (a[0] > a[4] && a[0] > a[8]) begin
         rad = ONE + a[0] - a[4] - a[8]; own = 0; o0 = 3; o1 = 1; o2 = 2;
         n0 = a[5] - a[7]; n1 = a[1] + a[3]; n2 = a[2] + a[6];
      end else if (a[4] > a[8]) begin
         rad = ONE + a[4] - a[0] - a[8]; own = 1; o0 = 3; o1 = 0; o2 = 2;
         n0 = a[6] - a[2]; n1 = a[1] + a[3]; n2 = a[5] + a[7];
      end else begin
         rad = ONE + a[8] - a[0] - a[4]; own = 2; o0 = 3; o1 = 0; o2 = 1;
         n0 = a[1] - a[3]; n1 = a[2] + a[6]; n2 = a[5] + a[7];
      end
      res = '{qx: '0, qy: '0, qz: '0, qw: sat_out(ONE), degen: 1'b1};
      if (rad <= 0) return res;
      r = int_sqrt(longint'(rad) << FB);
      if (r == 0) return res;
      d = 2 * r;
      q[own] = ((r + 1) >> 1) > CLAMP ? CLAMP : longint'((r + 1) >> 1);
      q[o0] = fixed_div(n0, d, CLAMP);
      q[o1] = fixed_div(n1, d, CLAMP);
      q[o2] = fixed_div(n2, d, CLAMP);
      sum = 0;
      for (int i = 0; i < 4; i++) begin
         mg = (q[i] < 0) ? longint'(-q[i]) : longint'(q[i]);
         sum += mg * mg;
      end
      len = int_sqrt(sum);
      if (len == 0) return res;
      res.qx = sat_out(fixed_div(q[0], len, 2 * ONE));
      res.qy = sat_out(fixed_div(q[1], len, 2 * ONE));
      res.qz = sat_out(fixed_div(q[2], len, 2 * ONE));
      res.qw = sat_out(fixed_div(q[3], len, 2 * ONE));
      res.degen = 1'b0;
      return res;
   endfunction

   function automatic word_type rand_entry();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return word_type'(ONE);
      if (sel == 1) return word_type'(-ONE);
      if (sel == 2) return word_type'($urandom);  // full width noise
      return word_type'(int'($urandom_range(0, 2 * ONE)) - int'(ONE));
   endfunction

   // rotation from an exact random unit quaternion-ish, then jittered
   function automatic matrix_type rand_rotation();
      real x, y, z, w, n;
      real e [9];
      matrix_type mx;
      x = $urandom_range(0, 20000) - 10000.0;
      y = $urandom_range(0, 20000) - 10000.0;
      z = $urandom_range(0, 20000) - 10000.0;
      w = $urandom_range(0, 20000) - 10000.0;
      n = $sqrt(x * x + y * y + z * z + w * w) + 1.0e-9;
      x /= n; y /= n; z /= n; w /= n;
      e[0] = 1 - 2 * (y * y + z * z); e[1] = 2 * (x * y + w * z); e[2] = 2 * (x * z - w * y);
      e[3] = 2 * (x * y - w * z); e[4] = 1 - 2 * (x * x + z * z); e[5] = 2 * (y * z + w * x);
      e[6] = 2 * (x * z + w * y); e[7] = 2 * (y * z - w * x); e[8] = 1 - 2 * (x * x + y * y);
      for (int i = 0; i < 9; i++)
         mx.m[i] = word_type'($rtoi(e[i] * ONE) + int'($urandom_range(0, 2)) - 1);
      return mx;
   endfunction

   function automatic matrix_type diag(longint d0, longint d1, longint d2, longint off);
      matrix_type mx;
      for (int i = 0; i < 9; i++) mx.m[i] = word_type'(off);
      mx.m[0] = word_type'(d0); mx.m[4] = word_type'(d1); mx.m[8] = word_type'(d2);
      return mx;
   endfunction

   // stimulus
   initial begin
      matrix_type mx;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // directed: each branch, ties, degenerate, extremes
      pending_matrices.push_back(diag(ONE, ONE, ONE, 0));
      pending_matrices.push_back(diag(ONE, -ONE, -ONE, 0));
      pending_matrices.push_back(diag(-ONE, ONE, -ONE, 0));
      pending_matrices.push_back(diag(-ONE, -ONE, ONE, 0));
      pending_matrices.push_back(diag(0, 0, 0, 0));
      pending_matrices.push_back(diag(-ONE, -ONE, -ONE, 0));
      pending_matrices.push_back(diag(-ONE, -ONE, -ONE, ONE));
      pending_matrices.push_back(diag(-ONE, -ONE, -ONE, -ONE));
      pending_matrices.push_back(diag(-1, -1, -ONE, ONE));
      pending_matrices.push_back(diag(0, 0, -ONE, 0));
      pending_matrices.push_back(diag(-ONE, 0, 0, -ONE));
      pending_matrices.push_back(diag(1, 0, 0, ONE));
      pending_matrices.push_back(diag(-ONE + 1, -ONE, ONE - 1, -ONE));
      pending_matrices.push_back(diag(-32768, -32768, -32768, -32768));
      pending_matrices.push_back(diag(32767, -32768, -32768, 32767));
      pending_matrices.push_back(diag(-32768, -32768, 32767, -32768));
      pending_matrices.push_back(diag(1, 0, 0, 0));
      for (int i = 0; i < 5; i++) pending_matrices.push_back(rand_rotation());
      wait (pending_matrices.size() == 0);
      // pause until the pipeline is empty, last transaction accepted first
      hold_off = 1'b1;
      repeat (2) @(posedge clock);
      wait (expected_quats.size() == 0);
      @(posedge clock);
      hold_off = 1'b0;
      for (int i = 0; i < N_RANDOM; i++) begin
         if ($urandom_range(0, 9) < 7) begin
            mx = rand_rotation();
         end else begin
            for (int k = 0; k < 9; k++) mx.m[k] = rand_entry();
         end
         pending_matrices.push_back(mx);
      end
      wait (pending_matrices.size() == 0);
      stim_done = 1'b1;
   end

   // driver
   always @(posedge clock) begin
      if (start && !busy && !reset) begin
         expected_quats.push_back(quat_from_matrix(
            {req_m[8], req_m[7], req_m[6], req_m[5], req_m[4],
             req_m[3], req_m[2], req_m[1], req_m[0]}));
      end
      if (reset || (start && busy)) begin
         // hold current transaction
      end else if (gap > 0) begin
         gap <= gap - 1;
         start <= 1'b0;
      end else if (pending_matrices.size() != 0 && !hold_off) begin
         matrix_type mx;
         mx = pending_matrices.pop_front();
         for (int i = 0; i < 9; i++) req_m[i] <= mx.m[i];
         start <= 1'b1;
         case ($urandom_range(0, 19))
            0:       gap <= $urandom_range(10, 40);
            1, 2, 3: gap <= $urandom_range(1, 3);
            default: gap <= 0;
         endcase
      end else begin
         start <= 1'b0;
      end
   end

   // monitor
   always @(posedge clock) begin
      quat_type exp_q;
      if (!reset && rsp_valid) begin
         if (expected_quats.size() == 0) begin
            $error("unexpected result qx=%0d qy=%0d qz=%0d qw=%0d", rsp_qx, rsp_qy,
                   rsp_qz, rsp_qw);
            errors++;
         end else begin
            exp_q = expected_quats.pop_front();
            if (rsp_qx !== exp_q.qx) begin
               $error("qx expected %0d actual %0d", exp_q.qx, rsp_qx); errors++;
            end
            if (rsp_qy !== exp_q.qy) begin
               $error("qy expected %0d actual %0d", exp_q.qy, rsp_qy); errors++;
            end
            if (rsp_qz !== exp_q.qz) begin
               $error("qz expected %0d actual %0d", exp_q.qz, rsp_qz); errors++;
            end
            if (rsp_qw !== exp_q.qw) begin
               $error("qw expected %0d actual %0d", exp_q.qw, rsp_qw); errors++;
            end
            if (rsp_degenerate !== exp_q.degen) begin
               $error("degenerate expected %0d actual %0d", exp_q.degen, rsp_degenerate);
               errors++;
            end
         end
      end
   end

   // end of run and cycle limit
   initial begin
      fork
         begin
            wait (stim_done && !start && expected_quats.size() == 0);
            repeat (DRAIN) @(posedge clock);
            if (errors == 0 && expected_quats.size() == 0) begin
               $display("CHECK OK");
            end else begin
               $display("CHECK FAILED");
            end
         end
         begin
            while (cycles < CYCLE_LIMIT) begin
               @(posedge clock);
               cycles++;
            end
            $display("CHECK FAILED");
         end
      join_any
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
design/rmq_pkg.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
verif/tb_rotation_matrix_to_quaternion.sv
